>>> src/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants
// Widths, thresholds and sequencer states for the lookahead curvature block.
// ----------------------------------------------------------------------------
package lmc_pkg;

  localparam int COORD_W         = 32;
  localparam int ARC_W           = 32;
  localparam int CURV_W          = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int CURV_FRAC_BITS  = 24;

  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W + 1;
  localparam int SQIN_W  = SQ_W + 1;
  localparam int SIDE_W  = SQIN_W / 2;
  localparam int SQREM_W = SIDE_W + 2;
  localparam int AB_W    = 2 * SIDE_W;
  localparam int PROD_W  = 3 * SIDE_W;
  localparam int AREA_W  = 2 * MAG_W + 1;
  localparam int DIV_SHIFT = 1 + COORD_FRAC_BITS + CURV_FRAC_BITS;
  localparam int NUM_W   = AREA_W + DIV_SHIFT;
  localparam int DREM_W  = PROD_W + 1;

  localparam logic [PROD_W-1:0] PROD_THR = PROD_W'(
    ((64'd1 << (3 * COORD_FRAC_BITS)) + 64'd999999999) / 64'd1000000000);

  typedef enum logic [3:0] {
    C_IDLE, C_SQX, C_SQY, C_ROOT, C_RWAIT, C_PAB, C_PLO, C_PHI,
    C_THR, C_M1, C_M2, C_DIV, C_DWAIT, C_DONE
  } curv_state_t;

  typedef struct packed {
    logic              done;
    logic [CURV_W-1:0] curv;
  } curv_rsp_t;

endpackage

>>> src/lmc_isqrt.sv
// ----------------------------------------------------------------------------
// lmc_isqrt: iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lmc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lmc_pkg::SQIN_W-1:0]  radicand,
  output logic                        done,
  output logic [lmc_pkg::SIDE_W-1:0]  root
);
  import lmc_pkg::*;

  localparam int CNT_W = $clog2(SIDE_W);

  logic               run_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQIN_W-1:0]  src_r;
  logic [SQREM_W-1:0] rem_r;
  logic [SIDE_W-1:0]  root_r;

  logic [SQREM_W+1:0] shrem;
  logic [SQREM_W+1:0] trial;
  logic               ge;
  logic [SQREM_W-1:0] rem_nxt;
  logic [SIDE_W-1:0]  root_nxt;

  always_comb begin
    shrem    = {rem_r, src_r[SQIN_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = (shrem >= trial);
    rem_nxt  = ge ? SQREM_W'(shrem - trial) : SQREM_W'(shrem);
    root_nxt = {root_r[SIDE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= CNT_W'(SIDE_W - 1);
        src_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        src_r  <= {src_r[SQIN_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> src/lmc_div.sv
// ----------------------------------------------------------------------------
// lmc_div: iterative saturating divider
// Restoring division giving a 32-bit quotient, saturated when it overflows.
// ----------------------------------------------------------------------------
module lmc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lmc_pkg::NUM_W-1:0]  num,
  input  logic [lmc_pkg::PROD_W-1:0] den,
  output logic                       done,
  output logic [lmc_pkg::CURV_W-1:0] quo
);
  import lmc_pkg::*;

  localparam int CNT_W = $clog2(CURV_W);
  localparam int CMP_W = PROD_W + CURV_W;

  logic              run_r;
  logic              done_r;
  logic              sat_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DREM_W-1:0] rem_r;
  logic [CURV_W-1:0] sreg_r;
  logic [PROD_W-1:0] den_r;

  logic [DREM_W-1:0] sh;
  logic              ge;
  logic              sat;

  always_comb begin
    sat = (CMP_W'(num) >= {den, CURV_W'(0)});
    sh  = {rem_r[PROD_W-1:0], sreg_r[CURV_W-1]};
    ge  = (sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= CNT_W'(CURV_W - 1);
        sat_r  <= sat;
        den_r  <= den;
        rem_r  <= DREM_W'(num[NUM_W-1:CURV_W]);
        sreg_r <= num[CURV_W-1:0];
      end else if (run_r) begin
        rem_r  <= ge ? (sh - {1'b0, den_r}) : sh;
        sreg_r <= {sreg_r[CURV_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = sat_r ? '1 : sreg_r;

endmodule

>>> src/lmc_curv.sv
// ----------------------------------------------------------------------------
// lmc_curv: Menger curvature sequencer
// Drives one shared multiplier, the square root unit and the divider.
// ----------------------------------------------------------------------------
module lmc_curv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lmc_pkg::COORD_W-1:0]  ox,
  input  logic [lmc_pkg::COORD_W-1:0]  oy,
  input  logic [lmc_pkg::COORD_W-1:0]  mx,
  input  logic [lmc_pkg::COORD_W-1:0]  my,
  input  logic [lmc_pkg::COORD_W-1:0]  cx,
  input  logic [lmc_pkg::COORD_W-1:0]  cy,
  output lmc_pkg::curv_rsp_t           rsp
);
  import lmc_pkg::*;

  curv_state_t state_r, state_nxt;
  logic [1:0]        side_r;
  logic [MAG_W-1:0]  magx_r [3];
  logic [MAG_W-1:0]  magy_r [3];
  logic              sux_r, suy_r, swx_r, swy_r;
  logic [SQ_W-1:0]   acc_r;
  logic [SIDE_W-1:0] len_r [3];
  logic [AB_W-1:0]   ab_r;
  logic [PROD_W-1:0] prod_r;
  logic [2*MAG_W-1:0] m1_r;
  logic [AREA_W-1:0] area_r;
  logic [CURV_W-1:0] k_r;

  logic [SIDE_W-1:0] mul_a, mul_b;
  logic [AB_W-1:0]   mul_p;
  logic              sq_start, sq_done, dv_start, dv_done;
  logic [SIDE_W-1:0] sq_root;
  logic [CURV_W-1:0] dv_quo;
  logic [COORD_W:0]  dx [3];
  logic [COORD_W:0]  dy [3];
  logic [2*MAG_W-1:0] m2;

  always_comb begin
    dx[0] = {mx[COORD_W-1], mx} - {ox[COORD_W-1], ox};
    dy[0] = {my[COORD_W-1], my} - {oy[COORD_W-1], oy};
    dx[1] = {cx[COORD_W-1], cx} - {mx[COORD_W-1], mx};
    dy[1] = {cy[COORD_W-1], cy} - {my[COORD_W-1], my};
    dx[2] = {cx[COORD_W-1], cx} - {ox[COORD_W-1], ox};
    dy[2] = {cy[COORD_W-1], cy} - {oy[COORD_W-1], oy};
  end

  assign mul_p = mul_a * mul_b;
  assign m2    = mul_p[2*MAG_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (start) state_nxt = C_SQX;
      C_SQX:   state_nxt = C_SQY;
      C_SQY:   state_nxt = C_ROOT;
      C_ROOT:  state_nxt = C_RWAIT;
      C_RWAIT: if (sq_done) state_nxt = (side_r == 2'd2) ? C_PAB : C_SQX;
      C_PAB:   state_nxt = C_PLO;
      C_PLO:   state_nxt = C_PHI;
      C_PHI:   state_nxt = C_THR;
      C_THR:   state_nxt = (prod_r < PROD_THR) ? C_DONE : C_M1;
      C_M1:    state_nxt = C_M2;
      C_M2:    state_nxt = C_DIV;
      C_DIV:   state_nxt = C_DWAIT;
      C_DWAIT: if (dv_done) state_nxt = C_DONE;
      C_DONE:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    rsp.done = 1'b0;
    rsp.curv = k_r;
    unique case (state_r)
      C_SQX: begin
        mul_a = SIDE_W'(magx_r[side_r]);
        mul_b = SIDE_W'(magx_r[side_r]);
      end
      C_SQY: begin
        mul_a = SIDE_W'(magy_r[side_r]);
        mul_b = SIDE_W'(magy_r[side_r]);
      end
      C_ROOT: sq_start = 1'b1;
      C_PAB: begin
        mul_a = len_r[0];
        mul_b = len_r[1];
      end
      C_PLO: begin
        mul_a = ab_r[SIDE_W-1:0];
        mul_b = len_r[2];
      end
      C_PHI: begin
        mul_a = ab_r[AB_W-1:SIDE_W];
        mul_b = len_r[2];
      end
      C_M1: begin
        mul_a = SIDE_W'(magx_r[0]);
        mul_b = SIDE_W'(magy_r[2]);
      end
      C_M2: begin
        mul_a = SIDE_W'(magy_r[0]);
        mul_b = SIDE_W'(magx_r[2]);
      end
      C_DIV:  dv_start = 1'b1;
      C_DONE: rsp.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        if (start) begin
          side_r <= 2'd0;
          k_r    <= '0;
          for (int i = 0; i < 3; i++) begin
            magx_r[i] <= dx[i][COORD_W] ? MAG_W'(-dx[i]) : dx[i][MAG_W-1:0];
            magy_r[i] <= dy[i][COORD_W] ? MAG_W'(-dy[i]) : dy[i][MAG_W-1:0];
          end
          sux_r <= dx[0][COORD_W];
          suy_r <= dy[0][COORD_W];
          swx_r <= dx[2][COORD_W];
          swy_r <= dy[2][COORD_W];
        end
      end
      C_SQX: acc_r <= SQ_W'(mul_p[2*MAG_W-1:0]);
      C_SQY: acc_r <= acc_r + SQ_W'(mul_p[2*MAG_W-1:0]);
      C_RWAIT: begin
        if (sq_done) begin
          len_r[side_r] <= sq_root;
          side_r        <= side_r + 2'd1;
        end
      end
      C_PAB: ab_r   <= mul_p;
      C_PLO: prod_r <= PROD_W'(mul_p);
      C_PHI: prod_r <= prod_r + PROD_W'({mul_p, SIDE_W'(0)});
      C_M1:  m1_r   <= mul_p[2*MAG_W-1:0];
      C_M2: begin
        if ((sux_r ^ swy_r) == (suy_r ^ swx_r)) begin
          area_r <= (m1_r >= m2) ? AREA_W'(m1_r - m2) : AREA_W'(m2 - m1_r);
        end else begin
          area_r <= AREA_W'(m1_r) + AREA_W'(m2);
        end
      end
      C_DWAIT: if (dv_done) k_r <= dv_quo;
      default: ;
    endcase
  end

  lmc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (SQIN_W'(acc_r)),
    .done     (sq_done),
    .root     (sq_root)
  );

  lmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   ({area_r, DIV_SHIFT'(0)}),
    .den   (prod_r),
    .done  (dv_done),
    .quo   (dv_quo)
  );

endmodule

>>> src/lookahead_max_curvature_top.sv
// ----------------------------------------------------------------------------
// lookahead_max_curvature_top: windowed maximum path curvature
// Scans path points and reports the largest Menger curvature in the window.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    point_x, point_y, point_arc, flags
//   out_     output     out_valid/out_ready  max_curvature, window_reached
//   cfg_     input      cfg_we               cfg_wdata (lookahead_window)
//
// A point needing a curvature takes three square roots, eleven shared
// multiplier steps and a divide, or nine steps and no divide if the side
// product is below PROD_THR. in_ready drops while a curvature runs or a
// result beat waits. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module lookahead_max_curvature_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lmc_pkg::COORD_W-1:0] in_point_x,
  input  logic [lmc_pkg::COORD_W-1:0] in_point_y,
  input  logic [lmc_pkg::ARC_W-1:0]   in_point_arc,
  input  logic                        in_scan_start,
  input  logic                        in_is_origin,
  input  logic                        in_path_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lmc_pkg::CURV_W-1:0]  out_max_curvature,
  output logic                        out_window_reached,
  input  logic                        cfg_we,
  input  logic [lmc_pkg::ARC_W-1:0]   cfg_wdata
);
  import lmc_pkg::*;

  logic [ARC_W-1:0]   win_r;
  logic [COORD_W-1:0] older_x_r, older_y_r, middle_x_r, middle_y_r;
  logic [ARC_W-1:0]   middle_arc_r, origin_arc_r;
  logic [CURV_W-1:0]  best_r;
  logic [1:0]         ps_r;
  logic               active_r, oseen_r, elig_r, busy_r, pend_end_r;
  logic               out_valid_r, out_wr_r;
  logic [CURV_W-1:0]  out_curv_r;

  logic               acc, eval, fire, curv_start;
  logic [ARC_W:0]     d;
  logic               oseen_e;
  logic [CURV_W-1:0]  best_max;
  curv_rsp_t          rsp;

  assign in_ready = !busy_r && !out_valid_r;
  assign acc      = in_valid && in_ready && (in_scan_start || active_r);

  always_comb begin
    d          = {1'b0, middle_arc_r} - {1'b0, origin_arc_r};
    eval       = !in_scan_start && (ps_r == 2'd2) && elig_r;
    fire       = eval && ($signed(d) > $signed({1'b0, win_r}));
    curv_start = acc && eval && !fire;
    oseen_e    = in_scan_start ? 1'b0 : oseen_r;
    best_max   = (rsp.curv > best_r) ? rsp.curv : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= ARC_W'(327680);
      older_x_r    <= '0;
      older_y_r    <= '0;
      middle_x_r   <= '0;
      middle_y_r   <= '0;
      middle_arc_r <= '0;
      origin_arc_r <= '0;
      best_r       <= '0;
      ps_r         <= 2'd0;
      active_r     <= 1'b0;
      oseen_r      <= 1'b0;
      elig_r       <= 1'b0;
      busy_r       <= 1'b0;
      pend_end_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (busy_r && rsp.done) begin
        busy_r <= 1'b0;
        best_r <= best_max;
        if (pend_end_r) begin
          out_valid_r <= 1'b1;
          out_curv_r  <= best_max;
          out_wr_r    <= 1'b0;
          active_r    <= 1'b0;
          pend_end_r  <= 1'b0;
        end
      end
      if (acc) begin
        if (fire) begin
          out_valid_r <= 1'b1;
          out_curv_r  <= best_r;
          out_wr_r    <= 1'b1;
          active_r    <= 1'b0;
        end else begin
          active_r <= 1'b1;
          if (in_scan_start) best_r <= '0;
          if (in_is_origin && !oseen_e) begin
            origin_arc_r <= in_point_arc;
          end
          oseen_r      <= oseen_e || in_is_origin;
          elig_r       <= oseen_e || in_is_origin;
          older_x_r    <= middle_x_r;
          older_y_r    <= middle_y_r;
          middle_x_r   <= in_point_x;
          middle_y_r   <= in_point_y;
          middle_arc_r <= in_point_arc;
          if (in_scan_start) ps_r <= 2'd1;
          else if (ps_r != 2'd2) ps_r <= ps_r + 2'd1;
          busy_r <= curv_start;
          if (in_path_end) begin
            if (curv_start) begin
              pend_end_r <= 1'b1;
            end else begin
              out_valid_r <= 1'b1;
              out_curv_r  <= in_scan_start ? '0 : best_r;
              out_wr_r    <= 1'b0;
              active_r    <= 1'b0;
            end
          end
        end
      end
    end
  end

  lmc_curv u_curv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (curv_start),
    .ox    (older_x_r),
    .oy    (older_y_r),
    .mx    (middle_x_r),
    .my    (middle_y_r),
    .cx    (in_point_x),
    .cy    (in_point_y),
    .rsp   (rsp)
  );

  assign out_valid          = out_valid_r;
  assign out_max_curvature  = out_curv_r;
  assign out_window_reached = out_wr_r;

`ifndef NO_ASSERTIONS
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("result beat raised while curvature in flight");

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> busy_r)
    else $error("curvature finished with nothing pending");

  a_pend_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_end_r |-> busy_r && active_r)
    else $error("path end held without a curvature in flight");
`endif

endmodule
